/* design/seven_segment_frame_builder_defines.svh */
// Assertion macros shared by the frame builder checker
`ifndef SEVEN_SEGMENT_FRAME_BUILDER_DEFINES_SVH
`define SEVEN_SEGMENT_FRAME_BUILDER_DEFINES_SVH

// clocked check, quiet while reset is held
`define SSFB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define SSFB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/ssfb_pkg.sv */
// Shared types, constants, glyph table and microcode word type for the frame builder
`timescale 1ns / 1ps
`default_nettype none
package ssfb_pkg;

  localparam int IMAGE_BYTES = 16;
  localparam int IDX_W       = 4;
  localparam int STEP_W      = 5;
  localparam int MAX_DIGITS  = 3;

  localparam logic [7:0] DATA_CMD  = 8'h40;
  localparam logic [7:0] ADDR_CMD  = 8'hC0;
  localparam logic [7:0] LAMP_BYTE = 8'hFF;
  localparam logic [7:0] DOT_BIT   = 8'h80;
  localparam logic [7:0] KEEP_IND  = 8'h0C;

  localparam logic [STEP_W-1:0] STEP_IMG_FIRST = 5'd2;
  localparam logic [STEP_W-1:0] STEP_IMG_LAST  = 5'd17;
  localparam logic [STEP_W-1:0] STEP_CTRL      = 5'd18;

  typedef enum logic [1:0] {
    CMD_SHOW       = 2'd0,
    CMD_CLEAR      = 2'd1,
    CMD_CLEAR_KEEP = 2'd2,
    CMD_LAMP       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    SRC_DATA  = 2'd0,
    SRC_ADDR  = 2'd1,
    SRC_IMAGE = 2'd2,
    SRC_CTRL  = 2'd3
  } src_t;

  // one microcode word
  typedef struct packed {
    src_t src;
    logic strobe;
    logic end_if_noctrl;
    logic end_prog;
  } uop_t;

  // sequencer to datapath
  typedef struct packed {
    logic             issue;
    src_t             src;
    logic [IDX_W-1:0] idx;
    logic             strobe;
    logic             last;
  } dp_ctl_t;

  function automatic logic [7:0] glyph(input logic [7:0] ch);
    logic [7:0] g;
    case (ch)
      "0", "O":      g = 8'h3f;
      "1":           g = 8'h06;
      "2":           g = 8'h5b;
      "3":           g = 8'h4f;
      "4":           g = 8'h66;
      "5", "S", "s": g = 8'h6d;
      "6":           g = 8'h7d;
      "7":           g = 8'h07;
      "8":           g = 8'h7f;
      "9":           g = 8'h6f;
      "A", "a":      g = 8'h77;
      "B", "b":      g = 8'h7c;
      "C":           g = 8'h39;
      "c":           g = 8'h58;
      "D", "d":      g = 8'h5e;
      "E", "e":      g = 8'h79;
      "F", "f":      g = 8'h71;
      "G", "g":      g = 8'h3d;
      "H":           g = 8'h76;
      "h":           g = 8'h74;
      "I", "i":      g = 8'h30;
      "J", "j":      g = 8'h1e;
      "L", "l":      g = 8'h38;
      "M", "m":      g = 8'h55;
      "N":           g = 8'h37;
      "n":           g = 8'h54;
      "o":           g = 8'h5c;
      "P", "p":      g = 8'h73;
      "Q", "q":      g = 8'h67;
      "R", "r":      g = 8'h50;
      "T", "t":      g = 8'h78;
      "U":           g = 8'h3e;
      "u":           g = 8'h1c;
      "W", "w":      g = 8'h6a;
      "Y", "y":      g = 8'h6e;
      "-":           g = 8'h40;
      default:       g = 8'h00;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

/* design/ssfb_if.sv */
// Request, result and register write channels of the frame builder
`timescale 1ns / 1ps
`default_nettype none
interface ssfb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       bank_select;
  logic [7:0] char_first;
  logic [7:0] char_second;
  logic [7:0] char_third;
  logic       dot_first;
  logic       dot_second;
  logic       dot_third;

  modport source (output valid, cmd, bank_select, char_first, char_second, char_third,
                  dot_first, dot_second, dot_third, input ready);
  modport sink   (input valid, cmd, bank_select, char_first, char_second, char_third,
                  dot_first, dot_second, dot_third, output ready);
  modport mon    (input valid, ready, cmd, bank_select, char_first, char_second,
                  char_third, dot_first, dot_second, dot_third);
endinterface

interface ssfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       new_frame;
  logic       last;

  modport source (output valid, out_byte, new_frame, last, input ready);
  modport sink   (input valid, out_byte, new_frame, last, output ready);
  modport mon    (input valid, ready, out_byte, new_frame, last);
endinterface

interface ssfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
  modport mon    (input valid, ready, data);
endinterface
`default_nettype wire

/* design/ssfb_urom.sv */
// Microcode store: one control word per frame step
`timescale 1ns / 1ps
`default_nettype none
module ssfb_urom (
  input  logic [ssfb_pkg::STEP_W-1:0] step,
  output ssfb_pkg::uop_t              uop
);

  always_comb begin
    uop = '{src: ssfb_pkg::SRC_DATA, strobe: 1'b1, end_if_noctrl: 1'b0, end_prog: 1'b1};
    case (step) inside
      5'd0: begin
        uop = '{src: ssfb_pkg::SRC_DATA, strobe: 1'b1, end_if_noctrl: 1'b0, end_prog: 1'b0};
      end
      5'd1: begin
        uop = '{src: ssfb_pkg::SRC_ADDR, strobe: 1'b1, end_if_noctrl: 1'b0, end_prog: 1'b0};
      end
      [ssfb_pkg::STEP_IMG_FIRST:5'd16]: begin
        uop = '{src: ssfb_pkg::SRC_IMAGE, strobe: 1'b0, end_if_noctrl: 1'b0, end_prog: 1'b0};
      end
      ssfb_pkg::STEP_IMG_LAST: begin
        // frames without a control byte stop here
        uop = '{src: ssfb_pkg::SRC_IMAGE, strobe: 1'b0, end_if_noctrl: 1'b1, end_prog: 1'b0};
      end
      ssfb_pkg::STEP_CTRL: begin
        uop = '{src: ssfb_pkg::SRC_CTRL, strobe: 1'b1, end_if_noctrl: 1'b0, end_prog: 1'b1};
      end
      default: begin
        uop = '{src: ssfb_pkg::SRC_CTRL, strobe: 1'b1, end_if_noctrl: 1'b0, end_prog: 1'b1};
      end
    endcase
  end

endmodule
`default_nettype wire

/* design/ssfb_seq.sv */
// Step counter and output handshake driven by the microcode store
`timescale 1ns / 1ps
`default_nettype none
module ssfb_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic              in_with_ctrl,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output ssfb_pkg::dp_ctl_t ctl
);

  logic                        busy_r, busy_nxt;
  logic                        with_ctrl_r, with_ctrl_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ssfb_pkg::STEP_W-1:0] step_r, step_nxt;
  ssfb_pkg::uop_t              uop;
  logic                        advance;
  logic                        finish;

  ssfb_urom u_urom (
    .step (step_r),
    .uop  (uop)
  );

  assign advance = busy_r && (!out_valid_r || out_ready);
  assign finish  = uop.end_prog || (uop.end_if_noctrl && !with_ctrl_r);

  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    with_ctrl_nxt = with_ctrl_r;
    if (in_accept) begin
      busy_nxt      = 1'b1;
      step_nxt      = '0;
      with_ctrl_nxt = in_with_ctrl;
    end else if (advance) begin
      if (finish) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_comb begin
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      with_ctrl_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      with_ctrl_r <= with_ctrl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready   = !busy_r;
  assign out_valid  = out_valid_r;
  assign ctl.issue  = advance;
  assign ctl.src    = uop.src;
  assign ctl.idx    = ssfb_pkg::IDX_W'(step_r - ssfb_pkg::STEP_IMG_FIRST);
  assign ctl.strobe = uop.strobe;
  assign ctl.last   = finish;

endmodule
`default_nettype wire

/* design/ssfb_dp.sv */
// Datapath: digit codes, display image, control register and result register
`timescale 1ns / 1ps
`default_nettype none
module ssfb_dp #(
  parameter int DIGIT_COUNT = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_accept,
  input  logic [1:0]        in_cmd,
  input  logic              in_bank,
  input  logic [7:0]        in_char [ssfb_pkg::MAX_DIGITS],
  input  logic              in_dot  [ssfb_pkg::MAX_DIGITS],
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  input  ssfb_pkg::dp_ctl_t ctl,
  output logic [7:0]        out_byte,
  output logic              out_new_frame,
  output logic              out_last
);

  ssfb_pkg::cmd_t cmd_r;
  logic           bank_r;
  logic [7:0]     code_r [DIGIT_COUNT];
  logic [7:0]     code   [ssfb_pkg::MAX_DIGITS];
  logic [7:0]     image_r [ssfb_pkg::IMAGE_BYTES];
  logic [7:0]     ctrl_r;
  logic [7:0]     byte_r, byte_nxt;
  logic           nf_r;
  logic           last_r;
  logic [7:0]     old_byte;
  logic [7:0]     new_byte;
  logic [2:0]     col;

  genvar k;
  generate
    for (k = 0; k < ssfb_pkg::MAX_DIGITS; k++) begin : g_digit
      if (k < DIGIT_COUNT) begin : g_used
        always_ff @(posedge clk) begin
          if (in_accept) begin
            code_r[k] <= ssfb_pkg::glyph(in_char[k]) | (in_dot[k] ? ssfb_pkg::DOT_BIT : 8'h00);
          end
        end
        assign code[k] = code_r[k];
      end else begin : g_blank
        assign code[k] = 8'h00;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= ssfb_pkg::cmd_t'(in_cmd);
      bank_r <= in_bank;
    end
  end

  // image byte idx holds column idx/2; even bytes carry bank 0 and the first bank 1 digit
  assign old_byte = image_r[ctl.idx];
  assign col      = ctl.idx[ssfb_pkg::IDX_W-1:1];

  always_comb begin
    new_byte = old_byte;
    case (cmd_r)
      ssfb_pkg::CMD_SHOW: begin
        if (!ctl.idx[0]) begin
          if (bank_r) begin
            new_byte[3] = code[0][col];
          end else begin
            new_byte[0] = code[0][col];
            new_byte[1] = code[1][col];
            new_byte[2] = code[2][col];
          end
        end else if (bank_r) begin
          new_byte[0] = code[1][col];
          new_byte[1] = code[2][col];
        end
      end
      ssfb_pkg::CMD_CLEAR:      new_byte = 8'h00;
      ssfb_pkg::CMD_CLEAR_KEEP: new_byte = ctl.idx[0] ? (old_byte & ssfb_pkg::KEEP_IND) : 8'h00;
      ssfb_pkg::CMD_LAMP:       new_byte = old_byte;
      default:                  new_byte = old_byte;
    endcase
  end

  always_comb begin
    case (ctl.src)
      ssfb_pkg::SRC_DATA:  byte_nxt = ssfb_pkg::DATA_CMD;
      ssfb_pkg::SRC_ADDR:  byte_nxt = ssfb_pkg::ADDR_CMD;
      ssfb_pkg::SRC_IMAGE: byte_nxt = (cmd_r == ssfb_pkg::CMD_LAMP) ? ssfb_pkg::LAMP_BYTE
                                                                     : new_byte;
      ssfb_pkg::SRC_CTRL:  byte_nxt = ctrl_r;
      default:             byte_nxt = ctrl_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ssfb_pkg::IMAGE_BYTES; i++) begin
        image_r[i] <= 8'h00;
      end
    end else if (ctl.issue && ctl.src == ssfb_pkg::SRC_IMAGE) begin
      image_r[ctl.idx] <= new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= 8'h8F;
    end else if (cfg_we) begin
      ctrl_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.issue) begin
      byte_r <= byte_nxt;
      nf_r   <= ctl.strobe;
      last_r <= ctl.last;
    end
  end

  assign out_byte      = byte_r;
  assign out_new_frame = nf_r;
  assign out_last      = last_r;

endmodule
`default_nettype wire

/* design/seven_segment_frame_builder.sv */
// Top level of the seven-segment LED driver frame builder
//
//   channel  dir  payload                                         handshake
//   in_ch    in   cmd, bank_select, char_*, dot_*                 valid/ready
//   out_ch   out  out_byte, new_frame, last                       valid/ready
//   cfg_ch   in   data (display control byte)                     valid/ready
//
// A request gives 19 frame bytes (show digits, lamp test) or 18 (both clears),
// one per cycle while out_ch is ready, as the microcode step counter walks the program.
// The next request is taken once the last byte is in the output register.
// Reset (rst_n low, synchronous) clears the image and sets control to 0x8F.
// A stalled out_ch holds the byte and the step counter; cfg_ch is always ready.
`timescale 1ns / 1ps
`default_nettype none
module seven_segment_frame_builder #(
  parameter int DIGIT_COUNT = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  ssfb_in_if.sink     in_ch,
  ssfb_out_if.source  out_ch,
  ssfb_cfg_if.sink    cfg_ch
);

  logic              in_accept;
  logic              in_with_ctrl;
  logic [7:0]        chars [ssfb_pkg::MAX_DIGITS];
  logic              dots  [ssfb_pkg::MAX_DIGITS];
  ssfb_pkg::dp_ctl_t ctl;

  assign in_accept    = in_ch.valid && in_ch.ready;
  assign in_with_ctrl = (in_ch.cmd == ssfb_pkg::CMD_SHOW) || (in_ch.cmd == ssfb_pkg::CMD_LAMP);
  assign chars[0]     = in_ch.char_first;
  assign chars[1]     = in_ch.char_second;
  assign chars[2]     = in_ch.char_third;
  assign dots[0]      = in_ch.dot_first;
  assign dots[1]      = in_ch.dot_second;
  assign dots[2]      = in_ch.dot_third;
  assign cfg_ch.ready = 1'b1;

  ssfb_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_with_ctrl (in_with_ctrl),
    .in_ready     (in_ch.ready),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .ctl          (ctl)
  );

  ssfb_dp #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_accept     (in_accept),
    .in_cmd        (in_ch.cmd),
    .in_bank       (in_ch.bank_select),
    .in_char       (chars),
    .in_dot        (dots),
    .cfg_we        (cfg_ch.valid),
    .cfg_data      (cfg_ch.data),
    .ctl           (ctl),
    .out_byte      (out_ch.out_byte),
    .out_new_frame (out_ch.new_frame),
    .out_last      (out_ch.last)
  );

endmodule
`default_nettype wire

/* design/ssfb_checker.sv */
// Port-level checker for the frame builder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "seven_segment_frame_builder_defines.svh"
module ssfb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_new_frame,
  input logic       out_last
);

  logic [1:0] open_r, open_nxt;

  // frames opened by a request and not yet closed by their last byte; a new request
  // may be taken while the previous last byte still waits, so up to two
  always_comb begin
    open_nxt = open_r;
    if (out_valid && out_ready && out_last) begin
      open_nxt = open_nxt - 2'd1;
    end
    if (in_valid && in_ready) begin
      open_nxt = open_nxt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 2'd0;
    end else begin
      open_r <= open_nxt;
    end
  end

  `SSFB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last), "stalled byte changed")
  `SSFB_ASSERT(a_busy_after_req, in_valid && in_ready |=> !in_ready, "request taken while busy")
  `SSFB_ASSERT(a_no_orphan, out_valid |-> open_r != 2'd0, "byte outside any frame")
  `SSFB_ASSERT(a_header, out_valid && out_new_frame && !out_last |-> out_byte == ssfb_pkg::DATA_CMD || out_byte == ssfb_pkg::ADDR_CMD, "bad frame header byte")
  `SSFB_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind seven_segment_frame_builder ssfb_checker u_ssfb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_byte      (out_ch.out_byte),
  .out_new_frame (out_ch.new_frame),
  .out_last      (out_ch.last)
);
`default_nettype wire

/* verif/ssfb_frame_checker.sv */
// Frame builder checker: models the display image and checks every frame byte
`timescale 1ns / 1ps
module ssfb_frame_checker #(
  parameter int DIGITS = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  ssfb_in_if.mon     req_mon,
  ssfb_out_if.mon    res_mon,
  ssfb_cfg_if.mon    cfg_mon,
  output int         fail_count,
  output int         bytes_due
);
  import ssfb_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       strobe;
    logic       last;
  } frame_byte_t;

  // characters with a glyph, paired in order with their segment codes
  localparam GLYPH_CHARS = "0O12345Ss6789AaBbCcDdEeFfGgHhIiJjLlMmNnoPpQqRrTtUuWwYy-";
  localparam int GLYPH_COUNT = $bits(GLYPH_CHARS) / 8;
  localparam logic [7:0] GLYPH_CODES [GLYPH_COUNT] = '{
    8'h3f, 8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h6d, 8'h6d, 8'h7d, 8'h07,
    8'h7f, 8'h6f, 8'h77, 8'h77, 8'h7c, 8'h7c, 8'h39, 8'h58, 8'h5e, 8'h5e, 8'h79,
    8'h79, 8'h71, 8'h71, 8'h3d, 8'h3d, 8'h76, 8'h74, 8'h30, 8'h30, 8'h1e, 8'h1e,
    8'h38, 8'h38, 8'h55, 8'h55, 8'h37, 8'h54, 8'h5c, 8'h73, 8'h73, 8'h67, 8'h67,
    8'h50, 8'h50, 8'h78, 8'h78, 8'h3e, 8'h1c, 8'h6a, 8'h6a, 8'h6e, 8'h6e, 8'h40
  };

  logic [7:0]  seg_table [256];
  logic [7:0]  image [IMAGE_BYTES];
  logic [7:0]  control;
  frame_byte_t frame_bytes_due [$];

  initial begin
    fail_count = 0;
    bytes_due  = 0;
    for (int i = 0; i < 256; i++) seg_table[i] = 8'h00;
    for (int k = 0; k < GLYPH_COUNT; k++)
      seg_table[GLYPH_CHARS[8*(GLYPH_COUNT-1-k) +: 8]] = GLYPH_CODES[k];
  end

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("%0t: mismatch on %s: expected %02h, got %02h", $realtime, what, want, got);
    fail_count++;
  endtask

  // update the image for one request and queue the frame it produces
  task automatic predict_frame(input cmd_t op, input logic bank, input logic [7:0] c0,
                               input logic [7:0] c1, input logic [7:0] c2,
                               input logic [2:0] dots);
    logic [7:0] chars [3];
    logic [7:0] seg [3];
    logic       with_ctrl;
    chars[0] = c0;
    chars[1] = c1;
    chars[2] = c2;
    with_ctrl = (op == CMD_SHOW) || (op == CMD_LAMP);
    for (int k = 0; k < 3; k++)
      seg[k] = (k < DIGITS) ? (seg_table[chars[k]] | (dots[k] ? DOT_BIT : 8'h00)) : 8'h00;
    case (op)
      CMD_SHOW: begin
        for (int j = 0; j < 8; j++) begin
          if (bank) begin
            image[2*j][3]   = seg[0][j];
            image[2*j+1][0] = seg[1][j];
            image[2*j+1][1] = seg[2][j];
          end else begin
            for (int k = 0; k < 3; k++) image[2*j][k] = seg[k][j];
          end
        end
      end
      CMD_CLEAR: begin
        for (int j = 0; j < IMAGE_BYTES; j++) image[j] = 8'h00;
      end
      CMD_CLEAR_KEEP: begin
        for (int j = 0; j < IMAGE_BYTES; j++) image[j] &= (j % 2) ? KEEP_IND : 8'h00;
      end
      default: ;
    endcase
    frame_bytes_due.push_back('{DATA_CMD, 1'b1, 1'b0});
    frame_bytes_due.push_back('{ADDR_CMD, 1'b1, 1'b0});
    for (int j = 0; j < IMAGE_BYTES; j++)
      frame_bytes_due.push_back('{(op == CMD_LAMP) ? LAMP_BYTE : image[j], 1'b0,
                                  !with_ctrl && (j == IMAGE_BYTES - 1)});
    if (with_ctrl) frame_bytes_due.push_back('{control, 1'b1, 1'b1});
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      for (int j = 0; j < IMAGE_BYTES; j++) image[j] = 8'h00;
      control = 8'h8f;
      frame_bytes_due.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) control = cfg_mon.data;
      // queue before popping: the oldest entry is still at the front
      if (req_mon.valid && req_mon.ready)
        predict_frame(cmd_t'(req_mon.cmd), req_mon.bank_select, req_mon.char_first,
                      req_mon.char_second, req_mon.char_third,
                      {req_mon.dot_third, req_mon.dot_second, req_mon.dot_first});
      if (res_mon.valid && res_mon.ready) begin
        if (frame_bytes_due.size() == 0) begin
          report_mismatch("unexpected byte", 8'h00, res_mon.out_byte);
        end else begin
          want = frame_bytes_due.pop_front();
          if (res_mon.out_byte !== want.data)
            report_mismatch("out_byte", want.data, res_mon.out_byte);
          if (res_mon.new_frame !== want.strobe)
            report_mismatch("new_frame", {7'd0, want.strobe}, {7'd0, res_mon.new_frame});
          if (res_mon.last !== want.last)
            report_mismatch("last", {7'd0, want.last}, {7'd0, res_mon.last});
        end
      end
    end
    bytes_due <= frame_bytes_due.size();
  end

endmodule

/* verif/tb_seven_segment_frame_builder.sv */
// Testbench top: drives requests and control writes into the frame builder
`timescale 1ns / 1ps
module tb_seven_segment_frame_builder;
  import ssfb_pkg::*;

  localparam int DIGITS          = 3;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_REQUESTS  = 68;
  localparam TEXT_CHARS = "0123456789AaBbCcdEeFGgHhIiJjLlMmNnOoPpqRrSsTtUuWwYy-";
  localparam int TEXT_LEN = $bits(TEXT_CHARS) / 8;

  logic clk;
  logic rst_n;
  logic hold_off;
  int   fail_count;
  int   bytes_due;
  int   sender_idle_pct;
  int   receiver_stall_pct;
  int   requests_sent;

  ssfb_in_if  in_ch ();
  ssfb_out_if out_ch ();
  ssfb_cfg_if cfg_ch ();

  seven_segment_frame_builder #(.DIGIT_COUNT(DIGITS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  ssfb_frame_checker #(.DIGITS(DIGITS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (in_ch),
    .res_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .bytes_due  (bytes_due)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
  end

  // long receiver hold-off while requests keep coming, so the block backs up
  initial begin
    hold_off = 1'b0;
    wait (requests_sent >= 40);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_request(input cmd_t op, input logic bank, input logic [7:0] c0,
                              input logic [7:0] c1, input logic [7:0] c2,
                              input logic [2:0] dots);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= op;
    in_ch.bank_select <= bank;
    in_ch.char_first  <= c0;
    in_ch.char_second <= c1;
    in_ch.char_third  <= c2;
    in_ch.dot_first   <= dots[0];
    in_ch.dot_second  <= dots[1];
    in_ch.dot_third   <= dots[2];
    do @(posedge clk); while (!in_ch.ready);
    requests_sent++;
  endtask

  // mostly displayable text, now and then any byte at all
  function automatic logic [7:0] pick_char();
    if ($urandom_range(4) == 0) return 8'($urandom_range(255));
    return TEXT_CHARS[8*$urandom_range(TEXT_LEN-1) +: 8];
  endfunction

  task automatic random_request();
    int   r;
    cmd_t op;
    r = $urandom_range(99);
    if (r < 64)      op = CMD_SHOW;
    else if (r < 76) op = CMD_CLEAR;
    else if (r < 88) op = CMD_CLEAR_KEEP;
    else             op = CMD_LAMP;
    send_request(op, 1'($urandom_range(1)), pick_char(), pick_char(), pick_char(),
                 3'($urandom_range(7)));
  endtask

  // only once the block has drained every byte of the previous requests
  task automatic write_control(input logic [7:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int         idle_pct [4];
    int         stall_pct [4];
    logic [7:0] ctrl_setting [4];
    idle_pct     = '{0, 78, 0, 22};
    stall_pct    = '{0, 0, 78, 22};
    ctrl_setting = '{8'h80, 8'($urandom_range(8'h8e, 8'h81)), 8'h8f,
                     8'($urandom_range(8'h8e, 8'h81))};
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_SHOW;
    in_ch.bank_select  = 1'b0;
    in_ch.char_first   = 8'h00;
    in_ch.char_second  = 8'h00;
    in_ch.char_third   = 8'h00;
    in_ch.dot_first    = 1'b0;
    in_ch.dot_second   = 1'b0;
    in_ch.dot_third    = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = 8'h00;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    requests_sent      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: both banks fully lit, lamp test, both clears, blank codes
    send_request(CMD_SHOW, 1'b0, "8", "8", "8", 3'b111);
    send_request(CMD_SHOW, 1'b1, "8", "8", "8", 3'b111);
    send_request(CMD_LAMP, 1'b0, 8'h00, 8'h00, 8'h00, 3'b000);
    send_request(CMD_CLEAR_KEEP, 1'b1, 8'hff, 8'hff, 8'hff, 3'b111);
    send_request(CMD_SHOW, 1'b1, "A", "b", "C", 3'b010);
    send_request(CMD_CLEAR, 1'b0, 8'h00, 8'h00, 8'h00, 3'b000);
    send_request(CMD_SHOW, 1'b0, 8'h00, 8'hff, 8'h00, 3'b000);
    send_request(CMD_SHOW, 1'b1, 8'h00, 8'h00, 8'h00, 3'b111);
    send_request(CMD_SHOW, 1'b0, "-", "O", "y", 3'b101);
    send_request(CMD_SHOW, 1'b0, 8'hff, 8'hff, 8'hff, 3'b000);
    send_request(CMD_CLEAR_KEEP, 1'b0, 8'h00, 8'h00, 8'h00, 3'b000);
    send_request(CMD_SHOW, 1'b1, "7", "h", "u", 3'b001);
    send_request(CMD_LAMP, 1'b1, 8'hff, 8'hff, 8'hff, 3'b111);
    send_request(CMD_CLEAR, 1'b1, 8'hff, 8'hff, 8'hff, 3'b111);

    for (int phase = 0; phase < 4; phase++) begin
      write_control(ctrl_setting[phase]);
      sender_idle_pct    = idle_pct[phase];
      receiver_stall_pct = stall_pct[phase];
      repeat (PHASE_REQUESTS) random_request();
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (bytes_due != 0);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
